/* sv/shdt_pkg.sv */
package shdt_pkg;

    typedef enum logic [1:0] {
        ACT_GET = 2'd0,
        ACT_SET = 2'd1,
        ACT_DEL = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] lookup_key;
        logic [63:0] new_value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] found_value;
        logic [10:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } sip_state_t;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int b);
        rotl = (x << b) | (x >> (64 - b));
    endfunction

    function automatic sip_state_t sip_round(input sip_state_t s);
        sip_state_t t;
        t = s;
        t.v0 = t.v0 + t.v1; t.v1 = rotl(t.v1, 13); t.v1 = t.v1 ^ t.v0;
        t.v0 = rotl(t.v0, 32);
        t.v2 = t.v2 + t.v3; t.v3 = rotl(t.v3, 16); t.v3 = t.v3 ^ t.v2;
        t.v0 = t.v0 + t.v3; t.v3 = rotl(t.v3, 21); t.v3 = t.v3 ^ t.v0;
        t.v2 = t.v2 + t.v1; t.v1 = rotl(t.v1, 17); t.v1 = t.v1 ^ t.v2;
        t.v2 = rotl(t.v2, 32);
        sip_round = t;
    endfunction

endpackage

/* sv/shdt_sip.sv */
// SipHash-2-4 over one 64-bit message word, one SipRound per cycle.
module shdt_sip
    import shdt_pkg::*;
#(
    parameter int KEY_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] key,
    input  logic [63:0] k0,
    input  logic [63:0] k1,
    output logic        done,
    output logic [63:0] hash
);
    localparam logic [63:0] LEN_WORD = 64'(KEY_BYTES) << 56;
    localparam logic [63:0] KEY_MASK =
        (KEY_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

    sip_state_t  st_reg, st_next;
    logic [3:0]  step_reg, step_next;
    logic        run_reg, run_next;
    logic [63:0] m0_reg, m1_reg;
    logic        two_blk;
    sip_state_t  rnd;

    assign two_blk = (KEY_BYTES >= 8);
    assign rnd = sip_round(st_reg);

    // steps: 0,1 block0 rounds; 2,3 block1 rounds; 4..7 finalization
    always_comb
    begin
        st_next = st_reg;
        step_next = step_reg;
        run_next = run_reg;
        done = 1'b0;
        if (start)
        begin
            st_next.v0 = k0 ^ SIP_C0;
            st_next.v1 = k1 ^ SIP_C1;
            st_next.v2 = k0 ^ SIP_C2;
            st_next.v3 = k1 ^ SIP_C3 ^ (two_blk ? (key & KEY_MASK) : (LEN_WORD | (key & KEY_MASK)));
            step_next = two_blk ? 4'd0 : 4'd2;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            st_next = rnd;
            step_next = step_reg + 4'd1;
            if (step_reg == 4'd1)
            begin
                st_next.v0 = rnd.v0 ^ m0_reg;
                st_next.v3 = rnd.v3 ^ m1_reg;
            end
            else if (step_reg == 4'd3)
            begin
                st_next.v0 = rnd.v0 ^ m1_reg;
                st_next.v2 = rnd.v2 ^ 64'hff;
            end
            else if (step_reg == 4'd7)
            begin
                run_next = 1'b0;
                done = 1'b1;
            end
        end
    end

    assign hash = rnd.v0 ^ rnd.v1 ^ rnd.v2 ^ rnd.v3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            step_reg <= 4'd0;
        end
        else
        begin
            run_reg <= run_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        if (start)
        begin
            m0_reg <= key & KEY_MASK;
            m1_reg <= two_blk ? LEN_WORD : (LEN_WORD | (key & KEY_MASK));
        end
    end

endmodule

/* sv/shdt_store.sv */
// Slot store: key/value memory plus occupied bits in a memory with a
// clearing pass after reset.
module shdt_store
#(
    parameter int CAPACITY = 1024
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [$clog2(CAPACITY)-1:0] raddr,
    output logic                        rocc,
    output logic [63:0]                 rkey,
    output logic [63:0]                 rval,
    input  logic                        we,
    input  logic [$clog2(CAPACITY)-1:0] waddr,
    input  logic                        wocc,
    input  logic [63:0]                 wkey,
    input  logic [63:0]                 wval,
    output logic                        clr_busy
);
    localparam int AW = $clog2(CAPACITY);

    logic [63:0] key_mem [CAPACITY];
    logic [63:0] val_mem [CAPACITY];
    logic        occ_mem [CAPACITY];
    logic [AW:0] clr_reg;

    assign clr_busy = !clr_reg[AW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (clr_busy)
            clr_reg <= clr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy)
            occ_mem[clr_reg[AW-1:0]] <= 1'b0;
        else if (we)
            occ_mem[waddr] <= wocc;
        if (we)
        begin
            key_mem[waddr] <= wkey;
            val_mem[waddr] <= wval;
        end
        rocc <= occ_mem[raddr];
        rkey <= key_mem[raddr];
        rval <= val_mem[raddr];
    end

endmodule

/* sv/siphash_double_hash_table_core.sv */
// Key/value hash table, open addressing with double hashing, SipHash-2-4.
// Requests: drive req and pulse start while busy is low; the item is
// taken at that edge. busy stays high until the result has been shown.
// Results: rsp is valid for one cycle while done is high; nothing may
// hold it off, and the block does not wait on the receiver.
// Sequence: the hash (one SipRound at a time), then per probe a memory
// read and then a compare/write, then a result state. An unused action
// skips the probes; a full scan checks at most CAPACITY slots.
// busy drops the cycle after done, so a new item is taken only once the
// last one has been answered. The probe loop through the slot memory
// sets the rate.
// Reset: salt registers clear, and a clearing pass frees every slot; busy
// is high during the pass. The APB port (64-bit registers at byte 8*i,
// 64-bit data) is usable throughout; the salt
// must only be changed while busy is low.
module siphash_double_hash_table_core
    import shdt_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int KEY_BYTES = 8,
    parameter int VALUE_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    output logic        done,
    output rsp_t        rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;
    localparam logic [63:0] KMASK =
        (KEY_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
    localparam logic [63:0] VMASK =
        (VALUE_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * VALUE_BYTES)) - 64'd1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HASH  = 5'b00010,
        S_READ  = 5'b00100,
        S_CHECK = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] salt_lo_reg, salt_hi_reg;
    logic [1:0]  act_reg;
    logic [63:0] key_reg, val_reg;
    logic [31:0] off_reg, off_next, stride_reg, stride_next;
    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]  status_reg, status_next;
    logic [63:0] found_reg, found_next;

    logic        hash_start, hash_done;
    logic [63:0] hash;
    logic        rocc, clr_busy;
    logic [63:0] rkey, rval;
    logic        we, wocc;
    logic [63:0] wkey, wval;
    logic        accept;

    assign pready = 1'b1;
    assign prdata = paddr[3] ? salt_hi_reg : salt_lo_reg;
    assign busy = (state_reg != S_IDLE) || clr_busy;
    assign accept = start && !busy;
    assign hash_start = accept;

    shdt_sip #(.KEY_BYTES(KEY_BYTES)) u_sip (
        .clk(clk), .rst_n(rst_n), .start(hash_start), .key(req.lookup_key),
        .k0(salt_lo_reg), .k1(salt_hi_reg), .done(hash_done), .hash(hash)
    );

    shdt_store #(.CAPACITY(CAPACITY)) u_store (
        .clk(clk), .rst_n(rst_n), .raddr(off_reg[AW-1:0]), .rocc(rocc),
        .rkey(rkey), .rval(rval), .we(we), .waddr(off_reg[AW-1:0]),
        .wocc(wocc), .wkey(wkey), .wval(wval), .clr_busy(clr_busy)
    );

    always_comb
    begin
        state_next = state_reg;
        off_next = off_reg;
        stride_next = stride_reg;
        left_next = left_reg;
        count_next = count_reg;
        status_next = status_reg;
        found_next = found_reg;
        we = 1'b0;
        wocc = 1'b0;
        wkey = key_reg;
        wval = val_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HASH;
                    status_next = ST_NOT_FOUND;
                    found_next = '0;
                    left_next = CW'(CAPACITY);
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    off_next = hash[31:0];
                    stride_next = hash[63:32] | 32'd1;
                    state_next = (act_reg == ACT_NONE) ? S_RESP : S_READ;
                end
            end
            S_READ:
                state_next = S_CHECK;
            S_CHECK:
            begin
                if (!rocc)
                begin
                    if (act_reg == ACT_SET)
                    begin
                        we = 1'b1;
                        wocc = 1'b1;
                        count_next = count_reg + 1'b1;
                        status_next = ST_OK;
                    end
                    state_next = S_RESP;
                end
                else if (rkey == key_reg)
                begin
                    we = (act_reg != ACT_GET);
                    wocc = (act_reg == ACT_SET);
                    wkey = key_reg;
                    if (act_reg == ACT_GET)
                        found_next = rval;
                    if (act_reg == ACT_DEL)
                        count_next = count_reg - 1'b1;
                    status_next = ST_OK;
                    state_next = S_RESP;
                end
                else if (left_reg == CW'(1))
                begin
                    if (act_reg == ACT_SET)
                        status_next = ST_FULL;
                    state_next = S_RESP;
                end
                else
                begin
                    left_next = left_reg - 1'b1;
                    off_next = off_reg + stride_reg;
                    state_next = S_READ;
                end
            end
            S_RESP:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign done = (state_reg == S_RESP);
    assign rsp.status = status_reg;
    assign rsp.found_value = found_reg;
    assign rsp.entry_count = 11'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            salt_lo_reg <= '0;
            salt_hi_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == 4'd0)
                    salt_lo_reg <= pwdata;
                else if (paddr == 4'd8)
                    salt_hi_reg <= pwdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg <= off_next;
        stride_reg <= stride_next;
        left_reg <= left_next;
        status_reg <= status_next;
        found_reg <= found_next;
        if (accept)
        begin
            act_reg <= req.action;
            key_reg <= req.lookup_key & KMASK;
            val_reg <= req.new_value & VMASK;
        end
    end

    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> busy)
        else $error("idle flag while working");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count overflow");
    a_write_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == S_CHECK))
        else $error("slot write outside check step");

endmodule
